@@ sv/nsr_pkg.sv @@
// Shared types and fixed constants for the Newton square root core.
// No dependencies; used by the core, the divider and the checker.
`default_nettype none
package nsr_pkg;

    // Widths fixed by the beat format
    localparam int RAD_W  = 32;      // signed radicand
    localparam int ROOT_W = 24;      // unsigned root
    localparam int G_W    = 32;      // working guess and quotient
    localparam int SQ_W   = 2 * G_W; // guess squared

    // Tolerance: stop once g*g <= (r + (r >> TOL_SHIFT)) << FRAC_BITS
    localparam int TOL_SHIFT = 20;

    // One quotient bit per divider cycle
    localparam int DIV_CNT_W = $clog2(G_W + 1);

    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

@@ sv/nsr_divider.sv @@
// Iterative restoring divider: one quotient bit per cycle, G_W quotient bits.
// Depends on nsr_pkg. The caller guarantees the quotient fits in G_W bits.
`default_nettype none
module nsr_divider #(
    parameter int NUM_W = 47
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [NUM_W-1:0]         numerator,
    input  wire logic [nsr_pkg::G_W-1:0]  divisor,
    output nsr_pkg::div_stat_t            stat,
    output logic      [nsr_pkg::G_W-1:0]  quotient
);

    localparam int G_W = nsr_pkg::G_W;
    localparam int HI_W = NUM_W - G_W;

    logic [G_W-1:0]                rem_reg, rem_next;
    logic [G_W-1:0]                quo_reg, quo_next;
    logic [G_W-1:0]                div_reg, div_next;
    logic [nsr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [G_W:0]                  trial;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[G_W-1]} - {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // upper numerator bits seed the remainder; they stay below the divisor
            rem_next  = {{(G_W-HI_W){1'b0}}, numerator[NUM_W-1:G_W]};
            quo_next  = numerator[G_W-1:0];
            div_next  = divisor;
            cnt_next  = nsr_pkg::DIV_CNT_W'(G_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[G_W]) begin
                rem_next = trial[G_W-1:0];
                quo_next = {quo_reg[G_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[G_W-2:0], quo_reg[G_W-1]};
                quo_next = {quo_reg[G_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == nsr_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
`default_nettype wire

@@ sv/newton_square_root_core.sv @@
// Top level of the Newton-Raphson square root core: sequencer, guess update,
// square and stop test. Depends on nsr_pkg and nsr_divider.
// Usage:
//   Input channel  s_valid / s_ready / s_radicand: one signed fixed-point
//   radicand per beat, FRAC_BITS fraction bits.
//   Result channel m_valid / m_ready / m_root / m_negative_error: one beat per
//   input beat, in order. m_root is unsigned with FRAC_BITS fraction bits.
//   A negative radicand returns root 0 with m_negative_error set; zero
//   returns zero without any division.
// Timing:
//   Each Newton step passes through the launch, the shared restoring divider
//   (one quotient bit per cycle, 32 bits, then a done pulse), the guess update,
//   the 32x32 square and the stop test. The result beat is loaded into the
//   output register once it is free, and s_ready rises in the same cycle;
//   steps runs from 1 to MAX_STEPS (about a dozen at most at FRAC_BITS = 16),
//   zero and negative input count 0.
// Reset (aresetn, synchronous, active low) drops any item in flight and any
// pending result beat. When the receiver stalls, the finished beat is held
// in the output register; the next item may be accepted and worked on, and
// its result waits until the held beat is taken.
`default_nettype none
module newton_square_root_core #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_STEPS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [nsr_pkg::RAD_W-1:0]  s_radicand,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic             [nsr_pkg::ROOT_W-1:0] m_root,
    output logic                                   m_negative_error
);

    localparam int RAD_W  = nsr_pkg::RAD_W;
    localparam int G_W    = nsr_pkg::G_W;
    localparam int SQ_W   = nsr_pkg::SQ_W;
    localparam int ROOT_W = nsr_pkg::ROOT_W;
    localparam int MAG_W  = RAD_W - 1;           // magnitude of a positive radicand
    localparam int NUM_W  = MAG_W + FRAC_BITS;   // radicand << FRAC_BITS
    localparam int LIM_W  = RAD_W + FRAC_BITS;   // tolerance limit
    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIV,
        ST_UPDATE,
        ST_SQUARE,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [MAG_W-1:0]    rad_reg, rad_next;
    logic [LIM_W-1:0]    limit_reg, limit_next;
    logic [G_W-1:0]      g_reg, g_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                neg_reg, neg_next;
    logic                m_valid_reg, m_valid_next;
    logic [ROOT_W-1:0]   m_root_reg, m_root_next;
    logic                m_neg_reg, m_neg_next;

    logic                 div_start;
    nsr_pkg::div_stat_t   div_stat;
    logic [G_W-1:0]       quotient;
    logic [NUM_W-1:0]     numerator;
    logic [RAD_W-1:0]     tol_sum;
    logic [G_W:0]         g_sum;
    logic [G_W-1:0]       g_half;
    logic [ROOT_W-1:0]    root_sat;

    assign numerator = {rad_reg, {FRAC_BITS{1'b0}}};
    assign div_start = (state_reg == ST_LAUNCH);

    // Tolerance term r + (r >> TOL_SHIFT) for the incoming beat
    assign tol_sum = {1'b0, s_radicand[MAG_W-1:0]}
                   + {1'b0, s_radicand[MAG_W-1:0] >> nsr_pkg::TOL_SHIFT};

    // Newton update: average of guess and quotient, truncated
    assign g_sum  = {1'b0, quotient} + {1'b0, g_reg};
    assign g_half = g_sum[G_W:1];

    // Clamp a root wider than the result field
    assign root_sat = (g_reg[G_W-1:ROOT_W] != '0) ? nsr_pkg::ROOT_MAX
                                                   : g_reg[ROOT_W-1:0];

    nsr_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (numerator),
        .divisor   (g_reg),
        .stat      (div_stat),
        .quotient  (quotient)
    );

    always_comb begin
        state_next   = state_reg;
        rad_next     = rad_reg;
        limit_next   = limit_reg;
        g_next       = g_reg;
        sq_next      = sq_reg;
        steps_next   = steps_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_root_next  = m_root_reg;
        m_neg_next   = m_neg_reg;

        // drop the held beat once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rad_next   = s_radicand[MAG_W-1:0];
                    limit_next = {tol_sum, {FRAC_BITS{1'b0}}};
                    g_next     = G_W'(1) << FRAC_BITS;   // start at 1.0
                    steps_next = '0;
                    neg_next   = s_radicand[RAD_W-1];
                    if (s_radicand[RAD_W-1] || (s_radicand == '0)) begin
                        // negative or zero: answer zero, skip iteration
                        g_next     = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // guard against a zero guess
                g_next     = (g_half == '0) ? G_W'(1) : g_half;
                steps_next = steps_reg + 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                sq_next    = SQ_W'(g_reg) * SQ_W'(g_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if ((sq_reg > SQ_W'(limit_reg)) && (steps_reg < STEP_W'(MAX_STEPS))) begin
                    state_next = ST_LAUNCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_root_next  = root_sat;
                    m_neg_next   = neg_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        rad_reg    <= rad_next;
        limit_reg  <= limit_next;
        g_reg      <= g_next;
        sq_reg     <= sq_next;
        steps_reg  <= steps_next;
        neg_reg    <= neg_next;
        m_root_reg <= m_root_next;
        m_neg_reg  <= m_neg_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_root           = m_root_reg;
    assign m_negative_error = m_neg_reg;

endmodule
`default_nettype wire

@@ sv/nsr_checker.sv @@
// Port-level checker for the Newton square root core, bound to the top level.
// Depends on nsr_pkg and newton_square_root_core.
`default_nettype none
module nsr_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic signed [nsr_pkg::RAD_W-1:0]  s_radicand,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic        [nsr_pkg::ROOT_W-1:0] m_root,
    input wire logic                              m_negative_error
);

    // Reset drops any pending result beat
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat survived reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_root)
                                   && $stable(m_negative_error)))
        else $error("stalled result beat changed");

    // A negative radicand always reports a zero root
    a_neg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_negative_error) |-> (m_root == '0))
        else $error("negative flag with nonzero root");

    // The core works on one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // A beat with an ordinary radicand that arrives while no result is pending
    // leaves the result idle: no result appears before any Newton step
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid && !s_radicand[nsr_pkg::RAD_W-1]
         && (s_radicand != '0)) |=> !m_valid)
        else $error("result appeared before any Newton step");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_radicand       (s_radicand),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_root           (m_root),
    .m_negative_error (m_negative_error)
);
`default_nettype wire
